[hw/rtl/rrf_pkg.sv]
// ----------------------------------------------------------------------------
// rrf_pkg: shared types and constants for the rational root finder.
// Holds the payload structs, the sequencer states and the status codes.
// ----------------------------------------------------------------------------
package rrf_pkg;

  localparam int MAX_DEGREE   = 7;
  localparam int MAX_DIVISORS = 16;
  localparam int STORE_DEPTH  = MAX_DEGREE + 1;
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W        = $clog2(STORE_DEPTH);
  localparam int DIV_W        = $clog2(MAX_DIVISORS);
  localparam int DCNT_W       = $clog2(MAX_DIVISORS + 1);
  localparam int ROOT_W       = $clog2(MAX_DEGREE + 1);

  localparam logic [1:0] STATUS_ROOT    = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOT = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic signed [7:0] coefficient;
    logic              last_coefficient;
  } rrf_in_t;

  typedef struct packed {
    logic signed [8:0] root_numerator;
    logic [7:0]        root_denominator;
    logic [1:0]        status;
    logic              last_result;
  } rrf_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_DIVP,
    ST_DIVQ,
    ST_PICK,
    ST_GCD,
    ST_EVAL,
    ST_TEST,
    ST_NEXT,
    ST_EMIT,
    ST_DONE
  } rrf_state_t;

  // Evaluator command and status between sequencer and arithmetic unit.
  typedef struct packed {
    logic              start;
    logic signed [8:0] p;
    logic [7:0]        q;
  } rrf_eval_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rrf_eval_sts_t;

endpackage

[hw/rtl/rrf_eval.sv]
// ----------------------------------------------------------------------------
// rrf_eval: exact polynomial evaluator.
// One shared 64-bit multiply-add, one coefficient per cycle (Horner form).
// ----------------------------------------------------------------------------
module rrf_eval import rrf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  rrf_eval_cmd_t           cmd,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [7:0]       coef [STORE_DEPTH],
  output rrf_eval_sts_t           sts
);

  logic                  busy;
  logic [CNT_W-1:0]      j;
  logic signed [63:0]    acc;
  logic signed [63:0]    qpow;
  logic signed [8:0]     p_r;
  logic [7:0]            q_r;
  logic signed [63:0]    qpow_next;
  logic signed [63:0]    acc_next;
  logic                  finish;

  // qpow already holds q^j when coefficient j is folded in, so each step is
  // a single multiply-add. qpow never exceeds 128^8 and the sum is taken
  // modulo 2^64 as in the exact test.
  assign qpow_next = qpow * $signed({56'd0, q_r});
  assign acc_next  = acc * 64'(p_r) + 64'(coef[j[IDX_W-1:0]]) * qpow;
  assign finish    = (j >= count) || (j >= CNT_W'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sts  <= '0;
    end else begin
      sts.done <= busy && !cmd.start && finish;
      if (cmd.start) begin
        busy <= 1'b1;
        p_r  <= cmd.p;
        q_r  <= cmd.q;
        acc  <= 64'(coef[0]);
        qpow <= $signed({56'd0, cmd.q});
        j    <= CNT_W'(1);
      end else if (busy) begin
        if (finish) begin
          busy     <= 1'b0;
          sts.zero <= (acc == 64'sd0);
        end else begin
          acc  <= acc_next;
          qpow <= qpow_next;
          j    <= j + CNT_W'(1);
        end
      end
    end
  end

endmodule

[hw/rtl/rational_root_finder.sv]
// ----------------------------------------------------------------------------
// rational_root_finder: rational root search over an integer polynomial.
// Loads coefficients, lists divisors, tests reduced candidates exactly.
// ----------------------------------------------------------------------------
//  channel   ports                          transaction
//  input     start, busy, in_item           start & !busy
//  result    result_valid, result           result_valid (no stall)
//
// Coefficients load one per cycle. After the marked constant term the block
// stays busy: each divisor list is found by repeated subtraction, each
// candidate takes a subtractive gcd and, when coprime, an exact evaluation
// on the shared multiply-add, plus bookkeeping in the PICK, TEST and NEXT
// states. There are 512 candidates at most. Reset is synchronous and clears
// the sequencer and counters. Results appear for one cycle each; the
// receiver cannot stall them.
module rational_root_finder import rrf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rrf_in_t  in_item,
  output logic     busy,
  output logic     result_valid,
  output rrf_out_t result
);

  rrf_state_t          state, state_next;
  logic signed [7:0]   coef [STORE_DEPTH];
  logic [CNT_W-1:0]    count;
  logic [7:0]          ndiv [MAX_DIVISORS];
  logic [7:0]          ddiv [MAX_DIVISORS];
  logic [DCNT_W-1:0]   np, nq;
  logic [7:0]          lead, cons;
  logic [7:0]          trial;
  logic [7:0]          rem;
  logic [DCNT_W-1:0]   i_idx, j_idx;
  logic                neg;
  logic [7:0]          ga, gb;
  logic [ROOT_W-1:0]   roots;
  logic                have_found;
  logic [7:0]          p_cur, q_cur;
  rrf_eval_cmd_t       ecmd;
  rrf_eval_sts_t       ests;
  logic                accept;
  logic [7:0]          abs_lead, abs_cons;
  logic [7:0]          target;
  logic                trial_end;
  logic                trial_step;
  logic                root_emit;

  assign accept = start && !busy;

  always_comb begin
    abs_lead = coef[0][7] ? 8'(-coef[0]) : 8'(coef[0]);
    abs_cons = coef[IDX_W'(count - CNT_W'(1))][7] ?
               8'(-coef[IDX_W'(count - CNT_W'(1))]) : 8'(coef[IDX_W'(count - CNT_W'(1))]);
  end

  assign target     = (state == ST_DIVP) ? cons : lead;
  assign trial_end  = (trial == target);
  assign trial_step = (rem < trial);
  assign p_cur      = ndiv[i_idx[DIV_W-1:0]];
  assign q_cur      = ddiv[j_idx[DIV_W-1:0]];

  always_comb begin
    ecmd.start = (state == ST_GCD) && (ga == gb) && (ga == 8'd1);
    ecmd.p     = neg ? -$signed({1'b0, p_cur}) : $signed({1'b0, p_cur});
    ecmd.q     = q_cur;
  end

  rrf_eval u_eval (
    .clk   (clk),
    .rst   (rst),
    .cmd   (ecmd),
    .count (count),
    .coef  (coef),
    .sts   (ests)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (accept && in_item.last_coefficient) state_next = ST_CHECK;
      ST_CHECK: state_next = (abs_lead == 8'd0 || abs_cons == 8'd0) ? ST_EMIT : ST_DIVP;
      ST_DIVP:  if (trial_end && trial_step) state_next = ST_DIVQ;
      ST_DIVQ:  if (trial_end && trial_step) state_next = ST_PICK;
      ST_PICK:  state_next = ST_GCD;
      ST_GCD:   if (ga == gb) state_next = (ga == 8'd1) ? ST_EVAL : ST_NEXT;
      ST_EVAL:  if (ests.done) state_next = ST_TEST;
      ST_TEST:  state_next = ST_NEXT;
      ST_NEXT:  if (j_idx + DCNT_W'(1) < nq || i_idx + DCNT_W'(1) < np || !neg)
                  state_next = ST_PICK;
                else state_next = ST_DONE;
      ST_EMIT:  state_next = ST_LOAD;
      ST_DONE:  state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    busy = (state != ST_LOAD);
  end

  // Pending root held one step so last_result can be set on the final one.
  logic        pend;
  rrf_out_t    pend_res;

  // A root found while another is pending releases the pending one.
  assign root_emit = (state == ST_TEST) && ests.zero && (roots < ROOT_W'(MAX_DEGREE)) && pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      result_valid <= 1'b0;
      pend         <= 1'b0;
      roots        <= '0;
      have_found   <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EMIT) || (state == ST_DONE) || root_emit;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (count < CNT_W'(STORE_DEPTH)) begin
              coef[count[IDX_W-1:0]] <= in_item.coefficient;
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_CHECK: begin
          lead  <= abs_lead;
          cons  <= abs_cons;
          np    <= '0;
          nq    <= '0;
          trial <= 8'd1;
          rem   <= abs_cons;
          roots <= '0;
          pend  <= 1'b0;
          have_found <= 1'b0;
        end
        ST_DIVP, ST_DIVQ: begin
          // rem is reduced by trial until it drops below it; a zero left
          // over marks trial as a divisor of the target.
          if (!trial_step) begin
            rem <= rem - trial;
          end else begin
            if (rem == 8'd0) begin
              if (state == ST_DIVP && np < DCNT_W'(MAX_DIVISORS)) begin
                ndiv[np[DIV_W-1:0]] <= trial;
                np <= np + DCNT_W'(1);
              end
              if (state == ST_DIVQ && nq < DCNT_W'(MAX_DIVISORS)) begin
                ddiv[nq[DIV_W-1:0]] <= trial;
                nq <= nq + DCNT_W'(1);
              end
            end
            if (trial_end) begin
              trial <= 8'd1;
              rem   <= lead;
            end else begin
              trial <= trial + 8'd1;
              rem   <= target;
            end
          end
          i_idx <= '0;
          j_idx <= '0;
          neg   <= 1'b0;
        end
        ST_PICK: begin
          ga <= p_cur;
          gb <= q_cur;
        end
        ST_GCD: begin
          if (ga > gb) ga <= ga - gb;
          else if (gb > ga) gb <= gb - ga;
        end
        ST_TEST: begin
          if (ests.zero && roots < ROOT_W'(MAX_DEGREE)) begin
            result       <= pend_res;
            pend         <= 1'b1;
            pend_res     <= '{ecmd.p, q_cur, STATUS_ROOT, 1'b0};
            roots        <= roots + ROOT_W'(1);
            have_found   <= 1'b1;
          end
        end
        ST_NEXT: begin
          if (j_idx + DCNT_W'(1) < nq) j_idx <= j_idx + DCNT_W'(1);
          else begin
            j_idx <= '0;
            if (i_idx + DCNT_W'(1) < np) i_idx <= i_idx + DCNT_W'(1);
            else begin
              i_idx <= '0;
              neg   <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          result       <= '{9'sd0, 8'd0, STATUS_INVALID, 1'b1};
          count        <= '0;
        end
        ST_DONE: begin
          count        <= '0;
          if (have_found) result <= '{pend_res.root_numerator,
                                      pend_res.root_denominator, STATUS_ROOT, 1'b1};
          else result <= '{9'sd0, 8'd0, STATUS_NO_ROOT, 1'b1};
        end
        default: ;
      endcase
    end
  end

  property p_no_busy_result_in_load;
    @(posedge clk) disable iff (rst) (state == ST_LOAD) |-> !ests.done;
  endproperty
  assert property (p_no_busy_result_in_load) else $error("evaluator active while loading");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (result_valid && result.last_result))
    else $error("search end without final result");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> (result.status == STATUS_INVALID))
    else $error("invalid status missing");

endmodule
